>>> src/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg: shared types and constants of the line pixel generator
// Coordinate, delta, error and color widths, the command codes, and the
// layout of one setup entry passed from the front end to the stepper.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int COLOR_BITS  = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic        [COLOR_BITS-1:0] color_t;

  // one classified command, with line setup already worked out for starts
  typedef struct packed {
    logic   is_start;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   step_x_neg;
    logic   step_y_neg;
    delta_t delta_x;
    delta_t delta_y;
    err_t   error_term;
    color_t color;
  } lpg_entry_t;

endpackage

>>> src/lpg_in_if.sv
// ----------------------------------------------------------------------------
// lpg_in_if: command channel of the line pixel generator
// Valid/ready channel carrying one start or step command per beat.
// ----------------------------------------------------------------------------
interface lpg_in_if import lpg_pkg::*; ();

  logic   valid;
  logic   ready;
  logic   command;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t line_color;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, line_color,
    output ready
  );

endinterface

>>> src/lpg_out_if.sv
// ----------------------------------------------------------------------------
// lpg_out_if: pixel channel of the line pixel generator
// Valid/ready channel carrying one rasterized pixel per beat.
// ----------------------------------------------------------------------------
interface lpg_out_if import lpg_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );

endinterface

>>> src/lpg_front.sv
// ----------------------------------------------------------------------------
// lpg_front: command front end
// Accepts command beats, classifies them, and for start commands works out
// step directions, absolute deltas and the initial error term.
// ----------------------------------------------------------------------------
module lpg_front import lpg_pkg::*; (
  lpg_in_if.sink     in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output lpg_entry_t push_data
);

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic                       x_fwd;
  logic                       y_fwd;
  delta_t                     dx;
  delta_t                     dy;

  // pass the handshake straight to the queue
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  // set up direction and absolute deltas
  always_comb begin
    x_fwd  = in_ch.start_x < in_ch.end_x;
    y_fwd  = in_ch.start_y < in_ch.end_y;
    diff_x = x_fwd ? ((COORD_BITS+1)'(in_ch.end_x) - (COORD_BITS+1)'(in_ch.start_x))
                   : ((COORD_BITS+1)'(in_ch.start_x) - (COORD_BITS+1)'(in_ch.end_x));
    diff_y = y_fwd ? ((COORD_BITS+1)'(in_ch.end_y) - (COORD_BITS+1)'(in_ch.start_y))
                   : ((COORD_BITS+1)'(in_ch.start_y) - (COORD_BITS+1)'(in_ch.end_y));
    dx     = diff_x[COORD_BITS-1:0];
    dy     = diff_y[COORD_BITS-1:0];
  end

  // build the queue entry
  always_comb begin
    push_data.is_start   = (in_ch.command == CMD_START);
    push_data.start_x    = in_ch.start_x;
    push_data.start_y    = in_ch.start_y;
    push_data.end_x      = in_ch.end_x;
    push_data.end_y      = in_ch.end_y;
    push_data.step_x_neg = ~x_fwd;
    push_data.step_y_neg = ~y_fwd;
    push_data.delta_x    = dx;
    push_data.delta_y    = dy;
    push_data.error_term = ERR_BITS'({1'b0, dx}) - ERR_BITS'({1'b0, dy});
    push_data.color      = in_ch.line_color;
  end

endmodule

>>> src/lpg_queue.sv
// ----------------------------------------------------------------------------
// lpg_queue: decoupling queue
// Short register FIFO between the front end and the stepper.
// ----------------------------------------------------------------------------
module lpg_queue import lpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  lpg_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output lpg_entry_t pop_data
);

  lpg_entry_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r;
  logic [QCNT_BITS-1:0] count_nxt;
  logic                 push;
  logic                 pop;

  assign push_ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/lpg_back.sv
// ----------------------------------------------------------------------------
// lpg_back: Bresenham stepper
// Holds the line state, takes one queue entry per cycle unless a held pixel
// stalls it, advances the current pixel and drives the pixel output register.
// ----------------------------------------------------------------------------
module lpg_back import lpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  lpg_entry_t pop_data,
  lpg_out_if.source  out_ch
);

  localparam int WIDE_BITS = ERR_BITS + 1;

  // line state
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t target_x_r, target_y_r;
  logic   step_x_neg_r, step_y_neg_r;
  delta_t delta_x_r, delta_y_r;
  err_t   error_term_r, error_term_nxt;
  color_t held_color_r;
  logic   busy_r, busy_nxt;

  // output register
  logic   out_valid_r;
  coord_t out_x_r;
  coord_t out_y_r;
  color_t out_color_r;
  logic   out_last_r;

  logic                        can_issue;
  logic                        take;
  logic                        active;
  logic signed [WIDE_BITS-1:0] twice;
  logic signed [WIDE_BITS-1:0] err_w;
  logic signed [WIDE_BITS-1:0] dx_w;
  logic signed [WIDE_BITS-1:0] dy_w;
  logic signed [WIDE_BITS-1:0] err_mid;
  logic signed [WIDE_BITS-1:0] err_end;
  logic                        move_x;
  logic                        move_y;
  coord_t                      x_mid;
  logic                        at_end;

  // a step while idle is dropped without needing the output slot
  assign can_issue = !out_valid_r || out_ch.ready;
  assign pop_ready = can_issue || (!pop_data.is_start && !busy_r);
  assign take      = pop_valid && pop_ready;
  assign active    = take && (pop_data.is_start || busy_r);

  // one Bresenham step from the held state
  always_comb begin
    twice   = {error_term_r, 1'b0};
    err_w   = WIDE_BITS'(error_term_r);
    dx_w    = WIDE_BITS'({1'b0, delta_x_r});
    dy_w    = WIDE_BITS'({1'b0, delta_y_r});
    move_x  = twice > -dy_w;
    x_mid   = cur_x_r;
    err_mid = err_w;
    if (move_x) begin
      x_mid   = step_x_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
      err_mid = err_w - dy_w;
    end
    move_y  = !((x_mid == target_x_r) && (cur_y_r == target_y_r)) && (twice < dx_w);
    cur_y_nxt = cur_y_r;
    err_end   = err_mid;
    if (move_y) begin
      cur_y_nxt = step_y_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
      err_end   = err_mid + dx_w;
    end
    cur_x_nxt      = x_mid;
    error_term_nxt = err_end[ERR_BITS-1:0];
    if (pop_data.is_start) begin
      cur_x_nxt      = pop_data.start_x;
      cur_y_nxt      = pop_data.start_y;
      error_term_nxt = pop_data.error_term;
    end
  end

  // endpoint test on the pixel being emitted
  always_comb begin
    if (pop_data.is_start) begin
      at_end = (pop_data.start_x == pop_data.end_x) && (pop_data.start_y == pop_data.end_y);
    end else begin
      at_end = (cur_x_nxt == target_x_r) && (cur_y_nxt == target_y_r);
    end
    busy_nxt = !at_end;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (active) begin
        busy_r <= busy_nxt;
      end
      if (active) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      target_x_r   <= '0;
      target_y_r   <= '0;
      step_x_neg_r <= 1'b0;
      step_y_neg_r <= 1'b0;
      delta_x_r    <= '0;
      delta_y_r    <= '0;
      error_term_r <= '0;
      held_color_r <= '0;
    end else if (active) begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      error_term_r <= error_term_nxt;
      if (pop_data.is_start) begin
        target_x_r   <= pop_data.end_x;
        target_y_r   <= pop_data.end_y;
        step_x_neg_r <= pop_data.step_x_neg;
        step_y_neg_r <= pop_data.step_y_neg;
        delta_x_r    <= pop_data.delta_x;
        delta_y_r    <= pop_data.delta_y;
        held_color_r <= pop_data.color;
      end
    end
  end

  // load the output beat
  always_ff @(posedge clk) begin
    if (active) begin
      out_x_r     <= cur_x_nxt;
      out_y_r     <= cur_y_nxt;
      out_color_r <= pop_data.is_start ? pop_data.color : held_color_r;
      out_last_r  <= at_end;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

endmodule

>>> src/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator: Bresenham line rasterizer
// Send a start beat (command = start) with two signed endpoints and a color;
// it yields the start pixel. Each step beat that follows yields the next
// pixel of the line; the endpoint pixel has last set and ends the line.
// A step beat with no line in progress yields nothing. A start beat while a
// line is in progress drops that line and begins the new one.
// Channels: in_ch carries command beats, out_ch carries pixel beats, both
// valid/ready. A beat moves at a clock edge with valid and ready high.
// A command beat taken on in_ch is written into the queue; the stepper pops
// the queue entry into its output register, from which the pixel leaves on
// out_ch.
// Throughput: one command and one pixel per cycle while out_ch is ready; the
// stepper works out each error update combinationally.
// A two-entry queue sits between the front end and the stepper. When the
// receiver stalls, the output register holds its pixel, the queue fills and
// in_ch.ready drops once both entries are taken.
// Reset (rst_n low, synchronous) empties the queue and output register and
// leaves the block idle with all line state cleared.
// ----------------------------------------------------------------------------
module line_pixel_generator import lpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lpg_in_if.sink    in_ch,
  lpg_out_if.source out_ch
);

  logic       push_valid;
  logic       push_ready;
  lpg_entry_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  lpg_entry_t pop_data;

  // classify commands and set up lines
  lpg_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple front end from stepper
  lpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // step the line and emit pixels
  lpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
